// ===== hdl/upd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and helper functions for the URL percent
// decoder core.
// ----------------------------------------------------------------------------
package upd_pkg;

    // Character codes
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [3:0] HEX_ALPHA  = 4'd10;

    // Number of result bytes one input byte can produce
    localparam int unsigned MAX_RESULTS = 3;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } upd_in_t;

    // Output transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } upd_out_t;

    // Escape tracking, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } upd_phase_t;

    // True for 0-9, A-F, a-f
    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_F));
    endfunction

    // Nibble value of a hex digit, zero for anything else
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        diff = 8'd0;
        if ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9))
            diff = c - CH_DIGIT_0;
        else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F))
            diff = c - CH_UPPER_A + {4'd0, HEX_ALPHA};
        else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F))
            diff = c - CH_LOWER_A + {4'd0, HEX_ALPHA};
        return diff[3:0];
    endfunction

    // Replace angle brackets by a space
    function automatic logic [7:0] sanitize(input logic [7:0] c);
        return ((c == CH_LT) || (c == CH_GT)) ? CH_SPACE : c;
    endfunction

    // Literal character: plus becomes a space, then sanitize
    function automatic logic [7:0] literal(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : sanitize(c);
    endfunction

endpackage

// ===== hdl/url_percent_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming decoder for form-encoded text: plus to space, percent escapes to
// bytes, angle brackets to space, held bytes flushed at end of string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one raw byte per
//   transaction with in_last on the final byte of a string. Output channel
//   (out_valid / out_ready / out_data) carries decoded bytes, out_last on the
//   final decoded byte of a string.
//   Each input byte is decoded in the cycle it is accepted and its results
//   (zero to three bytes) land in a three-entry result register; the first
//   result is visible in the cycle after acceptance.
//   Throughput is one input byte per cycle while each byte yields at most one
//   result and the receiver is ready. A byte yielding more results holds the
//   input until they drain; the input is taken again in the cycle the last of
//   them leaves.
//   in_ready depends on out_ready in that cycle: a new transaction is taken
//   when the result register is empty or its last entry is being drained.
//   When the receiver stalls, results hold and the input stalls behind them.
//   Reset clears the escape state and empties the result register.
// ----------------------------------------------------------------------------
module url_percent_decoder_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  upd_pkg::upd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output upd_pkg::upd_out_t out_data
);
    import upd_pkg::*;

    upd_phase_t phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    upd_out_t   q_reg [MAX_RESULTS];
    upd_out_t   q_next [MAX_RESULTS];
    logic [1:0] cnt_reg, cnt_next;

    upd_out_t   res [MAX_RESULTS];
    logic [1:0] res_cnt;
    logic       in_fire;
    logic       out_fire;

    // Handshake
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = q_reg[0];
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign in_fire   = in_valid && in_ready;

    // Decode one input byte into its result list
    always_comb
    begin
        logic [7:0] b;
        logic       done;
        logic [7:0] v;
        b          = in_data.in_byte;
        done       = 1'b0;
        v          = {hex_value(held_reg), hex_value(b)};
        res_cnt    = 2'd0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = '{out_byte: CH_SPACE, out_last: 1'b0};
        end

        // Resolve the pending escape
        unique case (phase_reg)
            PH_DIGIT:
            begin
                if (is_hex(b))
                begin
                    res[res_cnt].out_byte = sanitize(v);
                    res_cnt = res_cnt + 2'd1;
                    done = 1'b1;
                end
                else
                begin
                    res[res_cnt].out_byte = CH_PERCENT;
                    res_cnt = res_cnt + 2'd1;
                    res[res_cnt].out_byte = literal(held_reg);
                    res_cnt = res_cnt + 2'd1;
                end
            end
            PH_PCT:
            begin
                if (is_hex(b))
                begin
                    held_next  = b;
                    phase_next = PH_DIGIT;
                    done = 1'b1;
                end
                else
                begin
                    res[res_cnt].out_byte = CH_PERCENT;
                    res_cnt = res_cnt + 2'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Handle the byte as ordinary input
        if (!done)
        begin
            if (b == CH_PERCENT)
                phase_next = PH_PCT;
            else
            begin
                res[res_cnt].out_byte = literal(b);
                res_cnt = res_cnt + 2'd1;
            end
        end

        // Flush held bytes at end of string and mark the final result
        if (in_data.in_last)
        begin
            if (phase_next == PH_PCT)
            begin
                res[res_cnt].out_byte = CH_PERCENT;
                res_cnt = res_cnt + 2'd1;
            end
            else if (phase_next == PH_DIGIT)
            begin
                res[res_cnt].out_byte = CH_PERCENT;
                res_cnt = res_cnt + 2'd1;
                res[res_cnt].out_byte = literal(held_next);
                res_cnt = res_cnt + 2'd1;
            end
            phase_next = PH_IDLE;
            held_next  = 8'd0;
            if (res_cnt != 2'd0)
                res[res_cnt - 2'd1].out_last = 1'b1;
        end
    end

    // Load a new result list or drain one entry
    always_comb
    begin
        cnt_next  = cnt_reg;
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        q_next[2] = q_reg[2];
        if (in_fire)
        begin
            cnt_next  = res_cnt;
            q_next[0] = res[0];
            q_next[1] = res[1];
            q_next[2] = res[2];
        end
        else if (out_fire)
        begin
            cnt_next  = cnt_reg - 2'd1;
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_fire)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

endmodule

// ===== tb/url_percent_decoder_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_core_test
// Self-checking bench for the URL percent decoder core. A table of directed
// characters covers plus, angle brackets, valid escapes of both cases, escapes
// broken at either digit and flushes at end of string. Random strings of
// well-formed escapes with noise follow. Expected bytes are typed in where
// obvious, else taken from a local decoder model with its own escape state.
// Both channels idle at random; one receiver hold-off backs the core up into its input.
// ----------------------------------------------------------------------------
module url_percent_decoder_core_test;

    import upd_pkg::*;

    localparam int RANDOM_ITEMS   = 500;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PRINT_LIMIT    = 30;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    upd_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    upd_out_t out_data;

    // One directed character, with its results typed in where they are obvious
    typedef struct {
        upd_in_t    item;
        bit         typed;
        int         count;
        logic [7:0] want [3];
    } stim_row_t;

    stim_row_t  dir_rows [$];
    upd_out_t   decoded_q [$];

    // Local decoder model state
    upd_phase_t dec_phase;
    logic [7:0] dec_held;
    upd_out_t   dec_out [MAX_RESULTS];
    int         dec_cnt;

    int         err_count;
    int         result_idx;
    int         idle_cycles;
    bit         calm;
    bit         stall_req;
    int         hold_left;

    url_percent_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Character classes for the decoder model
    // ------------------------------------------------------------------
    function automatic bit hex_digit_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h41 + 8'd10;
        else if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h61 + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [7:0] scrub(input logic [7:0] c);
        return (c == CH_LT || c == CH_GT) ? CH_SPACE : c;
    endfunction

    function automatic logic [7:0] plain_char(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : scrub(c);
    endfunction

    // Append one decoded byte, dropping anything past the result limit
    function automatic void add_decoded(input logic [7:0] c);
        if (dec_cnt < MAX_RESULTS)
        begin
            dec_out[dec_cnt].out_byte = c;
            dec_out[dec_cnt].out_last = 1'b0;
            dec_cnt++;
        end
    endfunction

    // Decode one input character into dec_out / dec_cnt and advance the state
    function automatic void decode_step(input upd_in_t it);
        logic [7:0] b;
        bit         taken;
        upd_phase_t ph;
        b       = it.in_byte;
        taken   = 1'b0;
        ph      = dec_phase;
        dec_cnt = 0;
        case (ph)
            PH_DIGIT:
            begin
                if (hex_digit_ok(b))
                begin
                    add_decoded(scrub({nibble_of(dec_held), nibble_of(b)}));
                    taken = 1'b1;
                end
                else
                begin
                    add_decoded(CH_PERCENT);
                    add_decoded(plain_char(dec_held));
                end
                ph = PH_IDLE;
            end
            PH_PCT:
            begin
                if (hex_digit_ok(b))
                begin
                    dec_held = b;
                    ph       = PH_DIGIT;
                    taken    = 1'b1;
                end
                else
                begin
                    add_decoded(CH_PERCENT);
                    ph = PH_IDLE;
                end
            end
            default:
                ph = PH_IDLE;
        endcase
        if (!taken)
        begin
            if (b == CH_PERCENT)
                ph = PH_PCT;
            else
                add_decoded(plain_char(b));
        end
        // Flush held characters at end of string
        if (it.in_last)
        begin
            if (ph == PH_PCT)
                add_decoded(CH_PERCENT);
            else if (ph == PH_DIGIT)
            begin
                add_decoded(CH_PERCENT);
                add_decoded(plain_char(dec_held));
            end
            ph       = PH_IDLE;
            dec_held = 8'd0;
            if (dec_cnt > 0)
                dec_out[dec_cnt - 1].out_last = 1'b1;
        end
        dec_phase = ph;
    endfunction

    function automatic void queue_decoded();
        for (int i = 0; i < dec_cnt; i++)
            decoded_q.push_back(dec_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_row(input logic [7:0] b, input bit last, input bit typed,
                                    input int count, input logic [7:0] w0 = 8'h00,
                                    input logic [7:0] w1 = 8'h00,
                                    input logic [7:0] w2 = 8'h00);
        stim_row_t r;
        r.item.in_byte = b;
        r.item.in_last = last;
        r.typed        = typed;
        r.count        = count;
        r.want[0]      = w0;
        r.want[1]      = w1;
        r.want[2]      = w2;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] rand_hex();
        int k;
        k = $urandom_range(21);
        if (k < 10)
            return CH_DIGIT_0 + 8'(k);
        else if (k < 16)
            return CH_UPPER_A + 8'(k - 10);
        return CH_LOWER_A + 8'(k - 16);
    endfunction

    function automatic logic [7:0] rand_nonhex();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (hex_digit_ok(c))
            c = 8'($urandom_range(255));
        return c;
    endfunction

    // Offer one character and hold it until the core takes it
    task automatic send_char(input upd_in_t it);
        if (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Reset and stimulus
    // ------------------------------------------------------------------
    initial
    begin
        upd_in_t  it;
        upd_in_t  tok [$];
        upd_out_t w;
        int       sent;
        int       kind;
        bit       force_last;
        in_valid  <= 1'b0;
        in_data   <= '0;
        rst_n     <= 1'b0;
        dec_phase  = PH_IDLE;
        dec_held   = 8'd0;
        err_count  = 0;
        calm       = 1'b0;
        stall_req  = 1'b0;
        sent       = 0;

        // Directed characters: plain, extremes, escapes, broken escapes, flushes
        add_row(8'h61, 1'b0, 1'b1, 1, 8'h61);
        add_row(8'h00, 1'b0, 1'b1, 1, 8'h00);
        add_row(8'hFF, 1'b0, 1'b1, 1, 8'hFF);
        add_row(CH_PLUS, 1'b0, 1'b1, 1, CH_SPACE);
        add_row(CH_LT, 1'b0, 1'b1, 1, CH_SPACE);
        add_row(CH_GT, 1'b0, 1'b1, 1, CH_SPACE);
        add_row(CH_PERCENT, 1'b0, 1'b1, 0);
        add_row(8'h32, 1'b0, 1'b1, 0);
        add_row(8'h42, 1'b0, 1'b1, 1, CH_PLUS);
        add_row(CH_PERCENT, 1'b0, 1'b1, 0);
        add_row(8'h33, 1'b0, 1'b1, 0);
        add_row(8'h65, 1'b0, 1'b1, 1, CH_SPACE);
        add_row(CH_PERCENT, 1'b0, 1'b1, 0);
        add_row(8'h66, 1'b0, 1'b1, 0);
        add_row(8'h46, 1'b0, 1'b1, 1, 8'hFF);
        add_row(CH_PERCENT, 1'b0, 1'b0, 0);
        add_row(8'h34, 1'b0, 1'b0, 0);
        add_row(8'h67, 1'b0, 1'b1, 3, CH_PERCENT, 8'h34, 8'h67);
        add_row(CH_PERCENT, 1'b0, 1'b0, 0);
        add_row(CH_PERCENT, 1'b0, 1'b0, 0);
        add_row(8'h34, 1'b0, 1'b0, 0);
        add_row(8'h31, 1'b0, 1'b0, 0);
        add_row(CH_PERCENT, 1'b0, 1'b0, 0);
        add_row(8'h43, 1'b1, 1'b1, 2, CH_PERCENT, 8'h43);
        add_row(CH_PERCENT, 1'b1, 1'b1, 1, CH_PERCENT);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_char(dir_rows[i].item);
            decode_step(dir_rows[i].item);
            if (dir_rows[i].typed)
            begin
                for (int k = 0; k < dir_rows[i].count; k++)
                begin
                    w.out_byte = dir_rows[i].want[k];
                    w.out_last = dir_rows[i].item.in_last && (k == dir_rows[i].count - 1);
                    decoded_q.push_back(w);
                end
            end
            else
                queue_decoded();
        end

        // Random strings: plain characters, plus, angle brackets, well-formed and broken escapes
        while (sent < RANDOM_ITEMS)
        begin
            tok.delete();
            force_last = 1'b0;
            kind = $urandom_range(99);
            it.in_last = 1'b0;
            if (kind < 15)
            begin
                it.in_byte = 8'($urandom_range(255));
                tok.push_back(it);
            end
            else if (kind < 40)
            begin
                it.in_byte = 8'($urandom_range(8'h20, 8'h7E));
                tok.push_back(it);
            end
            else if (kind < 48)
            begin
                it.in_byte = CH_PLUS;
                tok.push_back(it);
            end
            else if (kind < 53)
            begin
                it.in_byte = $urandom_range(1) ? CH_LT : CH_GT;
                tok.push_back(it);
            end
            else
            begin
                it.in_byte = CH_PERCENT;
                tok.push_back(it);
                if (kind < 78)
                begin
                    it.in_byte = rand_hex();
                    tok.push_back(it);
                    it.in_byte = rand_hex();
                    tok.push_back(it);
                end
                else if (kind < 86)
                begin
                    it.in_byte = rand_nonhex();
                    tok.push_back(it);
                end
                else if (kind < 94)
                begin
                    it.in_byte = rand_hex();
                    tok.push_back(it);
                    it.in_byte = rand_nonhex();
                    tok.push_back(it);
                end
                else
                begin
                    // End the string with the escape still open
                    if ($urandom_range(1))
                    begin
                        it.in_byte = rand_hex();
                        tok.push_back(it);
                    end
                    force_last = 1'b1;
                end
            end
            if (force_last || $urandom_range(99) < 10)
                tok[tok.size() - 1].in_last = 1'b1;

            foreach (tok[j])
            begin
                calm = (sent >= 200) && (sent < 320);
                if (sent == 80)
                    stall_req = 1'b1;
                send_char(tok[j]);
                decode_step(tok[j]);
                queue_decoded();
                sent++;
            end
        end
        in_valid <= 1'b0;

        // Wait for the outstanding results, then a short quiet period
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: check each result transaction, idle at random, hold off once
    // ------------------------------------------------------------------
    initial
    begin
        upd_out_t exp_res;
        out_ready <= 1'b0;
        result_idx = 0;
        hold_left  = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("result %0d unexpected: byte %02h last %0b",
                                              result_idx, out_data.out_byte,
                                              out_data.out_last));
                else
                begin
                    exp_res = decoded_q.pop_front();
                    if (out_data.out_byte !== exp_res.out_byte)
                        report_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                                  result_idx, out_data.out_byte,
                                                  exp_res.out_byte));
                    if (out_data.out_last !== exp_res.out_last)
                        report_mismatch($sformatf("result %0d out_last %0b, expected %0b",
                                                  result_idx, out_data.out_last,
                                                  exp_res.out_last));
                end
                result_idx++;
            end
            // Decide ready for the next edge
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long
    // ------------------------------------------------------------------
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
